// ===== src/psr_pkg.sv =====
// Shared constants and controller/datapath interface types for the plucked string resonator.
`default_nettype none

package psr_pkg;

  localparam int MAX_DELAY_DEF = 2048;
  localparam int CHANNELS_DEF  = 2;

  localparam int SAMPLE_W   = 16;
  localparam int GAIN_W     = 16;
  localparam int DLY_W      = 12;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_DAMPING = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DECAY   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DELAY   = 2'd2;

  localparam logic [GAIN_W-1:0] DAMPING_RST = 16'hFFFF;
  localparam logic [GAIN_W-1:0] DECAY_RST   = 16'h8000;
  localparam logic [DLY_W-1:0]  DELAY_RST   = 12'd256;

  typedef struct packed {
    logic accept;
    logic mix_en;
    logic mul_en;
    logic wb_en;
  } psr_cmd_t;

  typedef struct packed {
    logic out_busy;
  } psr_sts_t;

endpackage

`default_nettype wire

// ===== src/psr_ctrl.sv =====
// Sequencer for the resonator: accept/read, mix, damping multiply, writeback.
`default_nettype none

module psr_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  psr_pkg::psr_sts_t sts,
  output psr_pkg::psr_cmd_t cmd
);
  import psr_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MIX  = 4'b0010,
    ST_MUL  = 4'b0100,
    ST_WB   = 4'b1000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  assign in_ready   = (state_r == ST_IDLE);
  assign cmd.accept = in_ready & in_valid;
  assign cmd.mix_en = (state_r == ST_MIX);
  assign cmd.mul_en = (state_r == ST_MUL);
  assign cmd.wb_en  = (state_r == ST_WB) & ~sts.out_busy;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_MIX;
      end
      ST_MIX:  state_nxt = ST_MUL;
      ST_MUL:  state_nxt = ST_WB;
      // hold until the output register can take the result
      ST_WB: begin
        if (!sts.out_busy) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_accept_to_mix: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept |=> cmd.mix_en) else $error("accepted transaction did not reach mix step");
  a_mix_to_mul: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.mix_en |=> cmd.mul_en) else $error("mix step not followed by multiply");
  a_wb_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WB && sts.out_busy) |=> (state_r == ST_WB && !in_ready))
    else $error("writeback left while output register busy");
`endif

endmodule

`default_nettype wire

// ===== src/psr_datapath.sv =====
// Delay RAM, per-channel loop state, feedback arithmetic and output register.
`default_nettype none

module psr_datapath #(
  parameter int MAX_DELAY = psr_pkg::MAX_DELAY_DEF,
  parameter int CHANNELS  = psr_pkg::CHANNELS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  psr_pkg::psr_cmd_t                 cmd,
  output psr_pkg::psr_sts_t                 sts,
  input  logic                              cfg_we,
  input  logic [psr_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [psr_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                              in_channel_index,
  input  logic signed [psr_pkg::SAMPLE_W-1:0] in_sample_in,
  input  logic                              in_block_end,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              out_channel_out,
  output logic signed [psr_pkg::SAMPLE_W-1:0] out_sample_out,
  output logic                              out_block_end_out
);
  import psr_pkg::*;

  localparam int AW        = $clog2(MAX_DELAY);
  localparam int DW        = AW + 1;
  localparam int LW        = (DW > DLY_W) ? DW : DLY_W;
  localparam int CW        = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int MEM_DEPTH = 2 ** (CW + AW);

  localparam logic [LW-1:0] MAXD_L   = LW'(MAX_DELAY);
  localparam logic [DW-1:0] MAXD_D   = DW'(MAX_DELAY);
  localparam logic [AW+1:0] MAXD_X   = (AW + 2)'(MAX_DELAY);
  localparam logic [AW-1:0] WP_LAST  = AW'(MAX_DELAY - 1);
  localparam logic signed [48:0] RND = 49'sh0_0000_8000_0000;
  localparam logic signed [17:0] SAT_HI = 18'sd32767;
  localparam logic signed [17:0] SAT_LO = -18'sd32768;

  // configuration
  logic [GAIN_W-1:0] damp_r;
  logic [GAIN_W-1:0] decay_r;
  logic [DLY_W-1:0]  dly_r;

  // per-channel loop state
  logic [AW-1:0]       wp_r   [CHANNELS];
  logic                wrap_r [CHANNELS];
  logic [SAMPLE_W-1:0] prev_r [CHANNELS];

  logic [SAMPLE_W-1:0] mem [MEM_DEPTH];

  // transaction in flight
  logic [CW-1:0]              ch_r;
  logic signed [SAMPLE_W-1:0] x_r;
  logic                       be_r;
  logic [SAMPLE_W-1:0]        rd_data_r;
  logic                       rd_ok_r;
  logic signed [31:0]         mix_r;
  logic signed [48:0]         prod_r;

  logic                       out_valid_r;
  logic                       out_ch_r;
  logic signed [SAMPLE_W-1:0] out_sample_r;
  logic                       out_be_r;

  // read address, formed from the input port during the accept cycle
  logic [CW-1:0]   ch_in;
  logic [AW-1:0]   wp_sel;
  logic [LW-1:0]   dl_ext;
  logic [DW-1:0]   dlen;
  logic [AW+1:0]   rdiff;
  logic [AW-1:0]   rp;
  logic            rd_ok;

  always_comb begin
    ch_in  = (CHANNELS > 1) ? CW'(in_channel_index) : '0;
    wp_sel = wp_r[ch_in];
    dl_ext = LW'(dly_r);
    if (dl_ext == '0) begin
      dlen = DW'(1);
    end else if (dl_ext > MAXD_L) begin
      dlen = MAXD_D;
    end else begin
      dlen = DW'(dl_ext);
    end
    rdiff = {2'b00, wp_sel} - {1'b0, dlen};
    if (rdiff[AW+1]) begin
      rp = AW'(rdiff + MAXD_X);
    end else begin
      rp = AW'(rdiff);
    end
    // entries not yet written since reset read as zero
    rd_ok = wrap_r[ch_in] | (rp < wp_sel);
  end

  logic signed [SAMPLE_W-1:0] delayed;
  logic signed [SAMPLE_W-1:0] prev;
  logic signed [16:0]         dif;
  logic signed [33:0]         mix_full;

  always_comb begin
    delayed  = rd_ok_r ? signed'(rd_data_r) : '0;
    prev     = signed'(prev_r[ch_r]);
    dif      = {prev[15], prev} - {delayed[15], delayed};
    // decay*prev + (1-decay)*delayed, rewritten as decay*(prev-delayed) + delayed
    mix_full = $signed({1'b0, decay_r}) * dif
             + $signed({{2{delayed[15]}}, delayed, 16'h0000});
  end

  logic signed [48:0] rnd;
  logic signed [16:0] fb;
  logic signed [17:0] ysum;
  logic signed [SAMPLE_W-1:0] y;

  always_comb begin
    rnd  = prod_r + RND;
    fb   = rnd[48:32];
    ysum = {fb[16], fb} + {{2{x_r[15]}}, x_r};
    if (ysum > SAT_HI) begin
      y = 16'sh7FFF;
    end else if (ysum < SAT_LO) begin
      y = 16'sh8000;
    end else begin
      y = ysum[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      damp_r  <= DAMPING_RST;
      decay_r <= DECAY_RST;
      dly_r   <= DELAY_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DAMPING: damp_r  <= cfg_data[GAIN_W-1:0];
        REG_DECAY:   decay_r <= cfg_data[GAIN_W-1:0];
        REG_DELAY:   dly_r   <= cfg_data[DLY_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CHANNELS; i++) begin
        wp_r[i]   <= '0;
        wrap_r[i] <= 1'b0;
        prev_r[i] <= '0;
      end
    end else begin
      if (cmd.mix_en) begin
        prev_r[ch_r] <= delayed;
      end
      if (cmd.wb_en) begin
        if (wp_r[ch_r] == WP_LAST) begin
          wp_r[ch_r]   <= '0;
          wrap_r[ch_r] <= 1'b1;
        end else begin
          wp_r[ch_r] <= wp_r[ch_r] + AW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wb_en) begin
      mem[{ch_r, wp_r[ch_r]}] <= y;
    end
    if (cmd.accept) begin
      rd_data_r <= mem[{ch_in, rp}];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      ch_r    <= ch_in;
      x_r     <= in_sample_in;
      be_r    <= in_block_end;
      rd_ok_r <= rd_ok;
    end
    if (cmd.mix_en) begin
      mix_r <= mix_full[31:0];
    end
    if (cmd.mul_en) begin
      prod_r <= $signed({1'b0, damp_r}) * mix_r;
    end
    if (cmd.wb_en) begin
      out_ch_r     <= ch_r[0];
      out_sample_r <= y;
      out_be_r     <= be_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.wb_en) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign sts.out_busy      = out_valid_r & ~out_ready;
  assign out_valid         = out_valid_r;
  assign out_channel_out   = out_ch_r;
  assign out_sample_out    = out_sample_r;
  assign out_block_end_out = out_be_r;

`ifndef ASSERT_OFF
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wb_en |-> (!out_valid_r || out_ready)) else $error("pending result overwritten");
  a_wb_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wb_en |=> out_valid_r) else $error("writeback did not raise out_valid");
  a_be_copy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wb_en |=> (out_block_end_out == $past(be_r))) else $error("block_end not carried");
`endif

endmodule

`default_nettype wire

// ===== src/plucked_string_resonator.sv =====
// Top level of the multichannel plucked string resonator.
//
//   channel  direction  handshake             payload
//   in_      input      in_valid/in_ready     channel_index, sample_in, block_end
//   out_     output     out_valid/out_ready   channel_out, sample_out, block_end_out
//   cfg_     input      cfg_we                cfg_index, cfg_data
//
// Each transaction steps through accept with delay RAM read, mix multiply,
// damping multiply, then writeback to the delay RAM and the output register.
// The single-port read-modify-write of the delay RAM plus the two chained
// multiplies set this sequence; a new transaction is taken once writeback is done.
// Writeback stalls while the output register holds a result not yet taken.
// Reset clears control, loop state, configuration and out_valid; the delay RAM is not swept,
// a per-channel wrap flag makes entries not yet written read as zero.
`default_nettype none

module plucked_string_resonator #(
  parameter int MAX_DELAY = psr_pkg::MAX_DELAY_DEF,
  parameter int CHANNELS  = psr_pkg::CHANNELS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_channel_index,
  input  logic signed [psr_pkg::SAMPLE_W-1:0] in_sample_in,
  input  logic                                in_block_end,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                out_channel_out,
  output logic signed [psr_pkg::SAMPLE_W-1:0] out_sample_out,
  output logic                                out_block_end_out,
  input  logic                                cfg_we,
  input  logic [psr_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [psr_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import psr_pkg::*;

  psr_cmd_t cmd;
  psr_sts_t sts;

  psr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  psr_datapath #(
    .MAX_DELAY (MAX_DELAY),
    .CHANNELS  (CHANNELS)
  ) u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_channel_index  (in_channel_index),
    .in_sample_in      (in_sample_in),
    .in_block_end      (in_block_end),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_channel_out   (out_channel_out),
    .out_sample_out    (out_sample_out),
    .out_block_end_out (out_block_end_out)
  );

endmodule

`default_nettype wire

// ===== bench/psr_string_checker.sv =====
// Checker for the plucked string resonator: tracks config, predicts each output sample, compares.
`default_nettype none

module psr_string_checker (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  input  wire logic                                in_ready,
  input  wire logic                                in_channel_index,
  input  wire logic signed [psr_pkg::SAMPLE_W-1:0] in_sample_in,
  input  wire logic                                in_block_end,
  input  wire logic                                out_valid,
  input  wire logic                                out_ready,
  input  wire logic                                out_channel_out,
  input  wire logic signed [psr_pkg::SAMPLE_W-1:0] out_sample_out,
  input  wire logic                                out_block_end_out,
  input  wire logic                                cfg_we,
  input  wire logic [psr_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [psr_pkg::CFG_DATA_W-1:0]      cfg_data,
  output int                                       fail_count,
  output int                                       pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import psr_pkg::*;

  localparam int RING   = MAX_DELAY_DEF;
  localparam int NCHAN  = CHANNELS_DEF;
  localparam int PTR_W  = $clog2(RING);

  typedef struct packed {
    logic                       ch;
    logic signed [SAMPLE_W-1:0] smp;
    logic                       be;
  } string_sample_t;

  logic [GAIN_W-1:0]          damping;
  logic [GAIN_W-1:0]          decay;
  logic [DLY_W-1:0]           delay_len;
  logic signed [SAMPLE_W-1:0] ring [NCHAN][RING];
  logic signed [SAMPLE_W-1:0] last_delayed [NCHAN];
  logic [PTR_W-1:0]           wr_pos [NCHAN];
  string_sample_t             expected_samples [$];

  // One trip around the string loop for one channel; updates the loop state.
  function automatic string_sample_t pluck_response(logic ch, logic signed [SAMPLE_W-1:0] x,
                                                    logic be);
    int unsigned    span;
    int unsigned    rd;
    longint         delayed;
    longint         prev;
    longint         dk;
    longint         ck;
    longint         gk;
    longint         mix;
    longint         fb;
    longint         y;
    string_sample_t r;
    span = delay_len;
    if (span == 0) span = 1;
    if (span > RING) span = RING;
    rd = (wr_pos[ch] + RING - span) % RING;
    delayed = ring[ch][rd];
    prev    = last_delayed[ch];
    dk  = decay;
    ck  = 65536 - dk;
    gk  = damping;
    mix = dk * prev + ck * delayed;
    // round to nearest, ties upward
    fb  = (gk * mix + 64'sd2147483648) >>> 32;
    y   = x + fb;
    if (y > 32767) y = 32767;
    else if (y < -32768) y = -32768;
    last_delayed[ch]       = delayed[SAMPLE_W-1:0];
    ring[ch][wr_pos[ch]]   = y[SAMPLE_W-1:0];
    wr_pos[ch]             = wr_pos[ch] + 1'b1;
    r.ch  = ch;
    r.smp = y[SAMPLE_W-1:0];
    r.be  = be;
    return r;
  endfunction

  task automatic flag_field(string field, int want, int got);
    fail_count++;
    $display("%0t %s mismatch: expected %0d, got %0d", $time, field, want, got);
  endtask

  always @(posedge clk) begin
    string_sample_t want;
    if (!rst_n) begin
      damping   = DAMPING_RST;
      decay     = DECAY_RST;
      delay_len = DELAY_RST;
      for (int c = 0; c < NCHAN; c++) begin
        last_delayed[c] = '0;
        wr_pos[c]       = '0;
        for (int i = 0; i < RING; i++) ring[c][i] = '0;
      end
      expected_samples.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_DAMPING: damping   = cfg_data[GAIN_W-1:0];
          REG_DECAY:   decay     = cfg_data[GAIN_W-1:0];
          REG_DELAY:   delay_len = cfg_data[DLY_W-1:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (expected_samples.size() == 0) begin
          fail_count++;
          $display("%0t unexpected transaction: channel %0d sample %0d block_end %0d",
                   $time, out_channel_out, out_sample_out, out_block_end_out);
        end else begin
          want = expected_samples.pop_front();
          if (out_channel_out !== want.ch)
            flag_field("channel_out", want.ch, out_channel_out);
          if (out_sample_out !== want.smp)
            flag_field("sample_out", want.smp, out_sample_out);
          if (out_block_end_out !== want.be)
            flag_field("block_end_out", want.be, out_block_end_out);
        end
      end
      if (in_valid && in_ready)
        expected_samples.push_back(pluck_response(in_channel_index, in_sample_in, in_block_end));
    end
    pending = expected_samples.size();
  end

endmodule

`default_nettype wire

// ===== bench/tb_plucked_string_resonator.sv =====
// Stimulus and verdict for the plucked string resonator testbench.
`default_nettype none

module tb_plucked_string_resonator;
  timeunit 1ns;
  timeprecision 1ps;
  import psr_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
  localparam int PHASES          = 6;
  localparam int ITEMS_PER_PHASE = 305;
  localparam int CYCLE_LIMIT     = 400000;
  localparam int HOLD_CYCLES     = 300;

  logic                       clk;
  logic                       rst_n;
  logic                       in_valid;
  logic                       in_ready;
  logic                       in_channel_index;
  logic signed [SAMPLE_W-1:0] in_sample_in;
  logic                       in_block_end;
  logic                       out_valid;
  logic                       out_ready;
  logic                       out_channel_out;
  logic signed [SAMPLE_W-1:0] out_sample_out;
  logic                       out_block_end_out;
  logic                       cfg_we;
  logic [CFG_IDX_W-1:0]       cfg_index;
  logic [CFG_DATA_W-1:0]      cfg_data;

  int fail_count;
  int pending;
  int cycle_count = 0;
  bit calm        = 0;
  bit hold_req    = 0;
  int pluck_left [2] = '{0, 0};

  int unsigned phase_damp  [PHASES] = '{65535, 0, 65535, 0, 32768, 0};
  int unsigned phase_decay [PHASES] = '{32768, 0, 65535, 0, 16384, 0};
  int unsigned phase_delay [PHASES] = '{3, 1, 17, 0, 2048, 0};

  plucked_string_resonator DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_channel_index  (in_channel_index),
    .in_sample_in      (in_sample_in),
    .in_block_end      (in_block_end),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_channel_out   (out_channel_out),
    .out_sample_out    (out_sample_out),
    .out_block_end_out (out_block_end_out),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  psr_string_checker u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_channel_index  (in_channel_index),
    .in_sample_in      (in_sample_in),
    .in_block_end      (in_block_end),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_channel_out   (out_channel_out),
    .out_sample_out    (out_sample_out),
    .out_block_end_out (out_block_end_out),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .fail_count        (fail_count),
    .pending           (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Receiver: random back-pressure, plus one long hold-off on request.
  initial begin
    int hold_left;
    hold_left = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (hold_req) begin
        hold_req  = 0;
        hold_left = HOLD_CYCLES;
        out_ready <= 1'b0;
      end else begin
        out_ready <= calm || ($urandom_range(0, 99) >= 21);
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after the transaction.
  task automatic offer_sample(logic ch, logic signed [SAMPLE_W-1:0] s, logic be);
    if (!calm && $urandom_range(0, 99) < 21) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    in_valid         <= 1'b1;
    in_channel_index <= ch;
    in_sample_in     <= s;
    in_block_end     <= be;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // Drain: stop offering, wait for every result, then let the pipeline go quiet.
  task automatic settle();
    in_valid <= 1'b0;
    wait (pending == 0);
    repeat (8) @(negedge clk);
  endtask

  // Mostly plucks: a short noise burst per channel, then the string rings on quiet input.
  task automatic next_excitation(output logic ch, output logic signed [SAMPLE_W-1:0] s,
                                 output logic be);
    int t;
    ch = 1'($urandom_range(0, 1));
    if (pluck_left[ch] > 0) begin
      pluck_left[ch]--;
      s = 16'($urandom_range(0, 65535));
    end else if ($urandom_range(0, 19) == 0) begin
      pluck_left[ch] = $urandom_range(2, 12);
      s = 16'($urandom_range(0, 65535));
    end else begin
      case ($urandom_range(0, 9))
        0:       s = 16'sh7FFF;
        1:       s = 16'sh8000;
        2, 3: begin
          t = $urandom_range(0, 63) - 32;
          s = t[SAMPLE_W-1:0];
        end
        4:       s = 16'($urandom_range(0, 65535));
        default: s = '0;
      endcase
    end
    be = ($urandom_range(0, 7) == 0);
  endtask

  initial begin
    logic                       ch;
    logic signed [SAMPLE_W-1:0] s;
    logic                       be;
    rst_n            = 1'b0;
    in_valid         = 1'b0;
    in_channel_index = 1'b0;
    in_sample_in     = '0;
    in_block_end     = 1'b0;
    cfg_we           = 1'b0;
    cfg_index        = REG_DAMPING;
    cfg_data         = '0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    // Reset settings: loop reads zeros, extremes pass straight through.
    offer_sample(1'b0, 16'sh7FFF, 1'b0);
    offer_sample(1'b1, 16'sh8000, 1'b1);
    offer_sample(1'b0, 16'sh0000, 1'b0);
    offer_sample(1'b1, 16'sh0001, 1'b0);
    offer_sample(1'b0, 16'shFFFF, 1'b1);
    settle();

    // Shortest loop at full gain: drive both saturation limits.
    cfg_write(REG_DAMPING, 16'hFFFF);
    cfg_write(REG_DECAY, 16'h0000);
    cfg_write(REG_DELAY, 16'h0001);
    offer_sample(1'b0, 16'sh7FFF, 1'b0);
    offer_sample(1'b0, 16'sh7FFF, 1'b0);
    offer_sample(1'b0, 16'sh7FFF, 1'b1);
    offer_sample(1'b0, 16'sh8000, 1'b0);
    offer_sample(1'b1, 16'sh8000, 1'b0);
    offer_sample(1'b1, 16'sh8000, 1'b1);
    settle();

    // Spare register index is dropped; zero delay with junk upper bits acts as one.
    cfg_write(REG_SPARE, 16'hFFFF);
    cfg_write(REG_DELAY, 16'hF000);
    cfg_write(REG_DECAY, 16'hFFFF);
    cfg_write(REG_DAMPING, 16'h0000);
    offer_sample(1'b0, 16'sd1000, 1'b0);
    offer_sample(1'b0, -16'sd1000, 1'b0);
    offer_sample(1'b1, 16'sh7FFF, 1'b1);
    settle();

    // Oversized delay clamps to the ring length.
    cfg_write(REG_DAMPING, 16'hFFFF);
    cfg_write(REG_DELAY, 16'h0FFF);
    offer_sample(1'b0, 16'sh7FFF, 1'b0);
    offer_sample(1'b1, 16'sh8000, 1'b1);
    settle();

    cfg_write(REG_DELAY, 16'd2048);
    cfg_write(REG_DECAY, 16'h0001);
    offer_sample(1'b0, 16'shFFFF, 1'b0);
    offer_sample(1'b1, 16'sh0000, 1'b1);
    settle();

    for (int p = 0; p < PHASES; p++) begin
      if (p == 3) begin
        phase_damp[p]  = $urandom_range(0, 65535);
        phase_decay[p] = $urandom_range(0, 65535);
        phase_delay[p] = $urandom_range(1, 64);
      end else if (p == 5) begin
        phase_damp[p]  = $urandom_range(0, 65535);
        phase_decay[p] = $urandom_range(0, 65535);
        phase_delay[p] = $urandom_range(0, 4095);
      end
      cfg_write(REG_DAMPING, phase_damp[p][CFG_DATA_W-1:0]);
      cfg_write(REG_DECAY, phase_decay[p][CFG_DATA_W-1:0]);
      cfg_write(REG_DELAY, phase_delay[p][CFG_DATA_W-1:0]);
      calm = (p == 3);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (p == 3 && n == 150) calm = 0;
        if (p == 1 && n == 100) hold_req = 1;
        if (p == 2 && n == 150) begin
          // hold the sender until the pipeline has fully drained
          in_valid <= 1'b0;
          wait (pending == 0);
          @(negedge clk);
        end
        next_excitation(ch, s, be);
        offer_sample(ch, s, be);
      end
      settle();
    end

    if (fail_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

`default_nettype wire
